>>> rtl/gwcu_pkg.sv
// Package for the warp control unit: sizes, operation codes and mask helpers.
package gwcu_pkg;

    localparam int WARP_CNT    = 8;
    localparam int BARRIER_CNT = 8;
    localparam int WARP_ID_W   = 3;
    localparam int BAR_ID_W    = 3;
    localparam int COUNT_W     = 8;
    localparam int PC_W        = 32;
    localparam int ONES_W      = 4;
    localparam int SPAWN_N_W   = 4;

    typedef logic [WARP_CNT-1:0] t_mask;

    typedef enum logic [2:0] {
        FUNC_SCHEDULE   = 3'd0,
        FUNC_SUSPEND    = 3'd1,
        FUNC_RESUME_ONE = 3'd2,
        FUNC_RESUME_ALL = 3'd3,
        FUNC_SPAWN      = 3'd4,
        FUNC_BARRIER    = 3'd5,
        FUNC_HALT       = 3'd6,
        FUNC_NOP        = 3'd7
    } t_func;

    // Count set bits of a warp mask.
    function automatic logic [ONES_W-1:0] mask_ones(input t_mask m);
        logic [ONES_W-1:0] c;
        c = '0;
        for (int i = 0; i < WARP_CNT; i++) begin
            c = c + ONES_W'(m[i]);
        end
        return c;
    endfunction

endpackage

>>> rtl/gpu_warp_control_unit.sv
// Warp control unit: active, stalled and barrier masks with a one-word-per-cycle step.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+----------------------------------------
//  command  | in        | start && !busy        | i_func, i_warp_id, i_spawn_count,
//           |           |                       | i_spawn_pc, i_barrier_index,
//           |           |                       | i_barrier_global, i_barrier_count
//  result   | out       | o_valid, one cycle    | o_sched_valid ... o_running
//
// Flow: a command word is captured in the input register, the step runs
// through one pass of combinational logic and lands in the result register,
// which raises o_valid with the result. One word is taken every
// cycle; busy stays low since each step reads the state the previous step
// wrote on the same edge it registered its result.
// Reset: synchronous, active low; warp 0 active, all other state clear; payloads not reset.
// Stalls: the receiver cannot hold results off, so nothing ever backs up.
module gpu_warp_control_unit
    import gwcu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [2:0]           i_func,
    input  logic [WARP_ID_W-1:0] i_warp_id,
    input  logic [COUNT_W-1:0]   i_spawn_count,
    input  logic [PC_W-1:0]      i_spawn_pc,
    input  logic [BAR_ID_W-1:0]  i_barrier_index,
    input  logic                 i_barrier_global,
    input  logic [COUNT_W-1:0]   i_barrier_count,
    output logic                 o_valid,
    output logic                 o_sched_valid,
    output logic [WARP_ID_W-1:0] o_sched_warp,
    output logic [7:0]           o_spawned_mask,
    output logic [PC_W-1:0]      o_spawned_pc,
    output logic                 o_done_now,
    output logic [7:0]           o_released_mask,
    output logic                 o_global_release,
    output logic [7:0]           o_active_mask,
    output logic [7:0]           o_stalled_mask,
    output logic                 o_running
);

    // Input register.
    logic                 r_in_valid;
    t_func                r_func;
    logic [WARP_ID_W-1:0] r_warp_id;
    logic [COUNT_W-1:0]   r_spawn_count;
    logic [PC_W-1:0]      r_spawn_pc;
    logic [BAR_ID_W-1:0]  r_barrier_index;
    logic                 r_barrier_global;
    logic [COUNT_W-1:0]   r_barrier_count;

    // Architectural state.
    t_mask                r_active;
    t_mask                r_stalled;
    t_mask                r_arrivals [BARRIER_CNT];
    logic                 r_spawn_pending;
    logic [SPAWN_N_W-1:0] r_spawn_warps;
    logic [PC_W-1:0]      r_spawn_start;

    // Next state and result of the step.
    t_mask                n_active;
    t_mask                n_stalled;
    t_mask                n_arr;
    logic                 n_arr_we;
    logic                 n_spawn_pending;
    logic [SPAWN_N_W-1:0] n_spawn_warps;
    logic [PC_W-1:0]      n_spawn_start;
    logic                 n_sched_valid;
    logic [WARP_ID_W-1:0] n_sched_warp;
    t_mask                n_spawned_mask;
    logic [PC_W-1:0]      n_spawned_pc;
    logic                 n_done_now;
    t_mask                n_released_mask;
    logic                 n_global_release;

    // Helpers.
    t_mask                wbit;
    t_mask                ready_mask;
    t_mask                arr_hit;
    logic                 one_active;
    logic [SPAWN_N_W-1:0] clamped_n;
    logic [BAR_ID_W-1:0]  bar_sel;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
        // capture payload on every accepted word
        if (start && !busy) begin
            r_func           <= t_func'(i_func);
            r_warp_id        <= i_warp_id;
            r_spawn_count    <= i_spawn_count;
            r_spawn_pc       <= i_spawn_pc;
            r_barrier_index  <= i_barrier_index;
            r_barrier_global <= i_barrier_global;
            r_barrier_count  <= i_barrier_count;
        end
    end

    assign wbit       = t_mask'(1) << r_warp_id;
    assign one_active = (mask_ones(r_active) == ONES_W'(1));
    assign clamped_n  = (r_spawn_count < COUNT_W'(WARP_CNT)) ?
                        r_spawn_count[SPAWN_N_W-1:0] : SPAWN_N_W'(WARP_CNT);
    assign bar_sel    = r_barrier_index;
    assign arr_hit    = r_arrivals[bar_sel] | wbit;

    always_comb begin
        n_active         = r_active;
        n_stalled        = r_stalled;
        n_arr            = arr_hit;
        n_arr_we         = 1'b0;
        n_spawn_pending  = r_spawn_pending;
        n_spawn_warps    = r_spawn_warps;
        n_spawn_start    = r_spawn_start;
        n_sched_valid    = 1'b0;
        n_sched_warp     = '0;
        n_spawned_mask   = '0;
        n_spawned_pc     = '0;
        n_done_now       = 1'b0;
        n_released_mask  = '0;
        n_global_release = 1'b0;
        ready_mask       = '0;

        unique case (r_func)
            FUNC_SCHEDULE: begin
                // apply a pending spawn once a single warp remains
                if (r_spawn_pending && one_active) begin
                    for (int i = 1; i < WARP_CNT; i++) begin
                        n_spawned_mask[i] = (SPAWN_N_W'(i) < r_spawn_warps);
                    end
                    n_active        = r_active | n_spawned_mask;
                    n_spawn_pending = 1'b0;
                    n_stalled[0]    = 1'b0;
                end
                if (n_spawned_mask != '0) begin
                    n_spawned_pc = r_spawn_start;
                end
                ready_mask = n_active & ~n_stalled;
                // lowest ready warp wins
                for (int i = WARP_CNT - 1; i >= 0; i--) begin
                    if (ready_mask[i]) begin
                        n_sched_valid = 1'b1;
                        n_sched_warp  = WARP_ID_W'(i);
                    end
                end
            end
            FUNC_SUSPEND:    n_stalled = r_stalled | wbit;
            FUNC_RESUME_ONE: n_stalled = r_stalled & ~wbit;
            FUNC_RESUME_ALL: n_stalled = '0;
            FUNC_SPAWN: begin
                if (clamped_n < SPAWN_N_W'(2) && one_active) begin
                    n_done_now = 1'b1;
                end else begin
                    n_spawn_pending = 1'b1;
                    n_spawn_warps   = clamped_n;
                    n_spawn_start   = r_spawn_pc;
                end
            end
            FUNC_BARRIER: begin
                if (r_barrier_count < COUNT_W'(2)) begin
                    n_done_now = 1'b1;
                end else begin
                    n_arr_we = 1'b1;
                    if (r_barrier_global) begin
                        if (mask_ones(arr_hit) == mask_ones(r_active)) begin
                            n_global_release = 1'b1;
                            n_arr            = '0;
                        end
                    end else if (COUNT_W'(mask_ones(arr_hit)) == r_barrier_count) begin
                        n_released_mask = arr_hit;
                        n_stalled       = r_stalled & ~arr_hit;
                        n_arr           = '0;
                    end
                end
            end
            FUNC_HALT: n_active = '0;
            default: ;
        endcase
    end

    // State update and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active        <= t_mask'(1);
            r_stalled       <= '0;
            r_spawn_pending <= 1'b0;
            r_spawn_warps   <= '0;
            r_spawn_start   <= '0;
            for (int b = 0; b < BARRIER_CNT; b++) begin
                r_arrivals[b] <= '0;
            end
            o_valid         <= 1'b0;
        end else begin
            o_valid <= r_in_valid;
            if (r_in_valid) begin
                r_active        <= n_active;
                r_stalled       <= n_stalled;
                r_spawn_pending <= n_spawn_pending;
                r_spawn_warps   <= n_spawn_warps;
                r_spawn_start   <= n_spawn_start;
                if (n_arr_we) begin
                    r_arrivals[bar_sel] <= n_arr;
                end
            end
        end
        // result payload, no reset
        if (r_in_valid) begin
            o_sched_valid    <= n_sched_valid;
            o_sched_warp     <= n_sched_warp;
            o_spawned_mask   <= n_spawned_mask;
            o_spawned_pc     <= n_spawned_pc;
            o_done_now       <= n_done_now;
            o_released_mask  <= n_released_mask;
            o_global_release <= n_global_release;
            o_active_mask    <= n_active;
            o_stalled_mask   <= n_stalled;
            o_running        <= (n_active != '0);
        end
    end

    // Every accepted word held in the input register yields a strobe on o_valid.
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |=> o_valid)
        else $error("accepted word lost its result");

    // A scheduled warp must be active and not stalled.
    a_sched_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_sched_valid) |->
            (o_active_mask[o_sched_warp] && !o_stalled_mask[o_sched_warp]))
        else $error("scheduled warp not ready");

    // Spawned warps never include warp 0, are active, and clear the request.
    a_spawn_applied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_spawned_mask != '0) |->
            (!o_spawned_mask[0] && (o_spawned_mask & ~o_active_mask) == '0
             && !r_spawn_pending))
        else $error("spawn applied inconsistently");

    // Warps released by a local barrier leave the stalled mask.
    a_release_unstalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_released_mask != '0) |-> ((o_stalled_mask & o_released_mask) == '0))
        else $error("released warp still stalled");

    // Reported masks equal the state written on the same edge.
    a_state_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_active_mask == r_active && o_stalled_mask == r_stalled))
        else $error("result masks differ from state");

endmodule
